[rtl/core/tbra_pkg.sv]
`default_nettype none

package tbra_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    localparam int CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START  = CFG_IDX_W'(1);

    localparam logic [6:0] WINDOW_RESET = 7'd60;

    // divider iteration counts
    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(33);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_SUB,
        ST_ADD,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] cnt;
    } t_bucket;

    // window of zero acts as one, above the ring size it saturates
    function automatic logic [31:0] eff_window(input logic [6:0] w);
        logic [31:0] wx;
        wx = 32'(w);
        if (wx == 32'd0) begin
            return 32'd1;
        end
        if (wx > 32'(MAX_WINDOW)) begin
            return 32'(MAX_WINDOW);
        end
        return wx;
    endfunction

endpackage

`default_nettype wire

[rtl/core/time_bucketed_rolling_average.sv]
// The shared shift-subtract unit runs 33 iterations for the bucket index modulo, then
//   64 for the sum/count divide (no divide runs when the total count has wrapped to zero).
// Input is not ready while an item is in work, and a result still waiting in the output
//   register holds the next one in its done state.
// Reset (synchronous, active low) clears totals, buckets (via valid bits), window = 60.
`default_nettype none

module time_bucketed_rolling_average
    import tbra_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,   // [31:0] now_seconds, [63:32] entry_value
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,   // [31:0] average
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [6:0]       r_window;
    logic [31:0]      r_now;
    logic [31:0]      r_entry;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_last_time;
    logic [IDX_W-1:0] r_last_index;
    logic [63:0]      r_total_sum;
    logic [31:0]      r_total_count;
    logic [31:0]      r_result;
    logic [31:0]      r_out_data;
    logic             r_out_valid;

    logic        in_xfer;
    logic        out_load;
    logic        later;
    logic [32:0] n_mod_arg;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic [63:0] div_quo;
    logic [31:0] div_rem;

    logic    rd_en;
    logic    wr_en;
    t_bucket rd_bucket;
    t_bucket wr_bucket;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    assign later     = r_now > r_last_time;
    assign n_mod_arg = {1'b0, s_axis_tdata[31:0] - r_last_time} + 33'(r_last_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_rsp.done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_SUB;
            ST_SUB:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_CHK;
            ST_CHK: begin
                n_state = (r_total_count == 32'd0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = MOD_STEPS;
        div_dividend  = {n_mod_arg, 31'd0};
        div_divisor   = eff_window(r_window);
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                div_req.start = s_axis_tvalid;
            end
            ST_READ: rd_en = 1'b1;
            ST_SUB:  wr_en = 1'b1;
            ST_CHK: begin
                div_req.start = (r_total_count != 32'd0);
                div_req.steps = DIV_STEPS;
                div_dividend  = r_total_sum;
                div_divisor   = r_total_count;
            end
            default: ;
        endcase
    end

    // a later time restarts the bucket, otherwise the sample accumulates
    always_comb begin
        if (later) begin
            wr_bucket.sum = 64'(r_entry);
            wr_bucket.cnt = 32'd1;
        end else begin
            wr_bucket.sum = rd_bucket.sum + 64'(r_entry);
            wr_bucket.cnt = rd_bucket.cnt + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= WINDOW_RESET;
            r_last_time   <= '0;
            r_last_index  <= '0;
            r_total_sum   <= '0;
            r_total_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window    <= i_cfg_data[6:0];
                    CFG_START:  r_last_time <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_SUB: begin
                    if (later) begin
                        r_total_sum   <= r_total_sum - rd_bucket.sum;
                        r_total_count <= r_total_count - rd_bucket.cnt;
                    end
                    r_last_time  <= r_now;
                    r_last_index <= r_idx;
                end
                ST_ADD: begin
                    r_total_sum   <= r_total_sum + 64'(r_entry);
                    r_total_count <= r_total_count + 32'd1;
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now   <= s_axis_tdata[31:0];
            r_entry <= s_axis_tdata[63:32];
        end
        if (r_state == ST_MOD && div_rsp.done) begin
            r_idx <= div_rem[IDX_W-1:0];
        end
        if (r_state == ST_CHK && r_total_count == 32'd0) begin
            r_result <= '1;
        end
        if (r_state == ST_DIV && div_rsp.done) begin
            r_result <= (div_quo[63:32] != 32'd0) ? '1 : div_quo[31:0];
        end
        if (out_load) begin
            r_out_data <= r_result;
        end
    end

    tbra_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_rsp       (div_rsp),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    tbra_bucket_store u_buckets (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_bucket),
        .o_rd_data (rd_bucket)
    );

    // registers change only between items
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/core/tbra_divider.sv]
`default_nettype none

module tbra_divider
    import tbra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_req    i_req,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output t_div_rsp         o_rsp,
    output logic [63:0]      o_quotient,
    output logic [31:0]      o_remainder
);

    logic [31:0]       r_rem;
    logic [63:0]       r_quo;
    logic [31:0]       r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [32:0] n_shift;
    logic [32:0] n_diff;
    logic        n_ge;

    // restoring shift-subtract, one quotient bit per cycle
    always_comb begin
        n_shift = {r_rem, r_quo[63]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[31:0] : n_shift[31:0];
            r_quo <= {r_quo[62:0], n_ge};
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[rtl/core/tbra_bucket_store.sv]
`default_nettype none

module tbra_bucket_store
    import tbra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_bucket          i_wr_data,
    output t_bucket               o_rd_data
);

    t_bucket                 r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   r_valid;
    t_bucket                 r_rd_data;
    logic                    r_rd_vld;

    // valid bits stand in for clearing the array at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

[rtl/core/tbra_checker.sv]
`default_nettype none

module tbra_checker
    import tbra_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // no result can be produced in the cycle after an input transfer
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(m_axis_tvalid))
        else $error("result appeared too soon after input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

bind time_bucketed_rolling_average tbra_checker u_tbra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
